// ===== rtl/core/slc_pkg.sv =====
// Package for the segment rectangle clipper: widths, codes, word and pipeline types.
package slc_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int NUM_WIDTH   = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * NUM_WIDTH;
  localparam int QDEPTH      = 4;
  localparam int QPTR        = $clog2(QDEPTH);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic        [COORD_WIDTH-1:0] mag_t;
  typedef logic signed [NUM_WIDTH-1:0]   num_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;

  localparam coord_t CLIP_LEFT_RST   = coord_t'(0);
  localparam coord_t CLIP_TOP_RST    = coord_t'(0);
  localparam coord_t CLIP_RIGHT_RST  = coord_t'(1023);
  localparam coord_t CLIP_BOTTOM_RST = coord_t'(1023);

  typedef enum logic [1:0] {
    CFG_LEFT   = 2'd0,
    CFG_TOP    = 2'd1,
    CFG_RIGHT  = 2'd2,
    CFG_BOTTOM = 2'd3
  } slc_cfg_t;

  typedef enum logic [1:0] {
    AX_NONE = 2'd0,
    AX_X    = 2'd1,
    AX_Y    = 2'd2
  } slc_axis_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } slc_in_t;

  typedef struct packed {
    logic   visible;
    coord_t out_start_x;
    coord_t out_start_y;
    coord_t out_end_x;
    coord_t out_end_y;
  } slc_out_t;

  // per-axis classification
  typedef struct packed {
    logic   zero;
    logic   in_rect;
    mag_t   den;
    num_t   ne;
    num_t   nx;
    coord_t ent;
    coord_t ext;
  } slc_axp_t;

  // front pipeline stage
  typedef struct packed {
    slc_in_t         pt;
    slc_axp_t [1:0]  ax;
    num_t            tmin_n;
    mag_t            tmin_d;
    slc_axis_t       a_axis;
    coord_t          a_bound;
    num_t            tmax_n;
    mag_t            tmax_d;
    slc_axis_t       b_axis;
    coord_t          b_bound;
    logic            ok_x;
    logic            ok_y;
    logic            chk;
    prod_t           p1;
    prod_t           p2;
    prod_t           p3;
    prod_t           p4;
  } slc_fst_t;

  // queued job between front and back
  typedef struct packed {
    logic      ok;
    slc_in_t   pt;
    slc_axis_t a_axis;
    coord_t    a_bound;
    mag_t      tmin_n;
    mag_t      tmin_d;
    slc_axis_t b_axis;
    coord_t    b_bound;
    mag_t      tmax_n;
    mag_t      tmax_d;
  } slc_job_t;

  // one endpoint in the divider pipeline
  typedef struct packed {
    slc_axis_t axis;
    coord_t    bound;
    coord_t    base;
    logic      neg;
    mag_t      den;
    mag_t      rem;
    mag_t      lo;
  } slc_ep_t;

  typedef struct packed {
    logic    ok;
    slc_in_t pt;
    slc_ep_t a;
    slc_ep_t b;
  } slc_bst_t;

  function automatic num_t to_num(mag_t m);
    return num_t'({1'b0, m});
  endfunction

endpackage

// ===== rtl/core/slc_front.sv =====
// Front end: clip registers, axis classification and entry/exit parameter selection.
module slc_front import slc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  logic [1:0] cfg_index,
  input  coord_t   cfg_data,
  input  logic     in_valid,
  output logic     in_ready,
  input  slc_in_t  in_data,
  input  logic     q_full,
  output logic     push,
  output slc_job_t job
);

  coord_t clip_left, clip_top, clip_right, clip_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= CLIP_LEFT_RST;
      clip_top    <= CLIP_TOP_RST;
      clip_right  <= CLIP_RIGHT_RST;
      clip_bottom <= CLIP_BOTTOM_RST;
    end else if (cfg_we) begin
      unique case (slc_cfg_t'(cfg_index))
        CFG_LEFT:   clip_left   <= cfg_data;
        CFG_TOP:    clip_top    <= cfg_data;
        CFG_RIGHT:  clip_right  <= cfg_data;
        CFG_BOTTOM: clip_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  slc_fst_t   st [1:5];
  slc_fst_t   st_next [1:5];
  logic [5:1] v;
  logic       adv;

  assign adv      = !v[5] || !q_full;
  assign in_ready = adv;

  // stage 1: deltas and numerators
  always_comb begin
    coord_t s [2];
    coord_t e [2];
    coord_t lo [2];
    coord_t hi [2];
    num_t   d, nd;
    logic   pos;
    s[0] = in_data.start_x;  s[1] = in_data.start_y;
    e[0] = in_data.end_x;    e[1] = in_data.end_y;
    lo[0] = clip_left;       lo[1] = clip_top;
    hi[0] = clip_right;      hi[1] = clip_bottom;
    st_next[1] = '0;
    st_next[1].pt = in_data;
    for (int i = 0; i < 2; i++) begin
      d   = num_t'(e[i]) - num_t'(s[i]);
      nd  = -d;
      pos = d > num_t'(0);
      st_next[1].ax[i].zero    = d == num_t'(0);
      st_next[1].ax[i].in_rect = (s[i] >= lo[i]) && (s[i] <= hi[i]);
      st_next[1].ax[i].den    = pos ? d[COORD_WIDTH-1:0] : nd[COORD_WIDTH-1:0];
      st_next[1].ax[i].ne     = pos ? num_t'(lo[i]) - num_t'(s[i])
                                    : num_t'(s[i]) - num_t'(hi[i]);
      st_next[1].ax[i].nx     = pos ? num_t'(hi[i]) - num_t'(s[i])
                                    : num_t'(s[i]) - num_t'(lo[i]);
      st_next[1].ax[i].ent    = pos ? lo[i] : hi[i];
      st_next[1].ax[i].ext    = pos ? hi[i] : lo[i];
    end
  end

  // stage 2: x axis against the initial range [0,1]
  always_comb begin
    slc_axp_t ax;
    logic     a_set, b_set;
    ax = st[1].ax[0];
    st_next[2] = st[1];
    a_set = !ax.zero && (ax.ne > num_t'(0));
    b_set = !ax.zero && (ax.nx < to_num(ax.den));
    st_next[2].tmin_n  = a_set ? ax.ne : num_t'(0);
    st_next[2].tmin_d  = a_set ? ax.den : mag_t'(1);
    st_next[2].a_axis  = a_set ? AX_X : AX_NONE;
    st_next[2].a_bound = ax.ent;
    st_next[2].tmax_n  = b_set ? ax.nx : num_t'(1);
    st_next[2].tmax_d  = b_set ? ax.den : mag_t'(1);
    st_next[2].b_axis  = b_set ? AX_X : AX_NONE;
    st_next[2].b_bound = ax.ext;
    if (ax.zero)
      st_next[2].ok_x = ax.in_rect;
    else if (a_set && b_set)
      st_next[2].ok_x = ax.nx > ax.ne;
    else if (a_set)
      st_next[2].ok_x = to_num(ax.den) > ax.ne;
    else if (b_set)
      st_next[2].ok_x = ax.nx > num_t'(0);
    else
      st_next[2].ok_x = 1'b1;
  end

  // stage 3: y axis cross products
  always_comb begin
    st_next[3] = st[2];
    st_next[3].p1 = prod_t'(st[2].ax[1].ne) * prod_t'(to_num(st[2].tmin_d));
    st_next[3].p2 = prod_t'(st[2].tmin_n) * prod_t'(to_num(st[2].ax[1].den));
    st_next[3].p3 = prod_t'(st[2].ax[1].nx) * prod_t'(to_num(st[2].tmax_d));
    st_next[3].p4 = prod_t'(st[2].tmax_n) * prod_t'(to_num(st[2].ax[1].den));
  end

  // stage 4: y axis update
  always_comb begin
    slc_axp_t ax;
    logic     upd_a, upd_b;
    ax = st[3].ax[1];
    st_next[4] = st[3];
    upd_a = !ax.zero && (st[3].p1 > st[3].p2);
    upd_b = !ax.zero && (st[3].p3 < st[3].p4);
    if (upd_a) begin
      st_next[4].tmin_n  = ax.ne;
      st_next[4].tmin_d  = ax.den;
      st_next[4].a_axis  = AX_Y;
      st_next[4].a_bound = ax.ent;
    end
    if (upd_b) begin
      st_next[4].tmax_n  = ax.nx;
      st_next[4].tmax_d  = ax.den;
      st_next[4].b_axis  = AX_Y;
      st_next[4].b_bound = ax.ext;
    end
    st_next[4].ok_y = ax.zero ? ax.in_rect : 1'b1;
    st_next[4].chk  = !ax.zero;
  end

  // stage 5: final range products
  always_comb begin
    st_next[5] = st[4];
    st_next[5].p1 = prod_t'(st[4].tmax_n) * prod_t'(to_num(st[4].tmin_d));
    st_next[5].p2 = prod_t'(st[4].tmin_n) * prod_t'(to_num(st[4].tmax_d));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[4:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k <= 5; k++) st[k] <= st_next[k];
    end
  end

  assign push = v[5] && !q_full;

  always_comb begin
    job = '0;
    job.ok      = st[5].ok_x && st[5].ok_y && (!st[5].chk || (st[5].p1 > st[5].p2));
    job.pt      = st[5].pt;
    job.a_axis  = st[5].a_axis;
    job.a_bound = st[5].a_bound;
    job.tmin_n  = st[5].tmin_n[COORD_WIDTH-1:0];
    job.tmin_d  = st[5].tmin_d;
    job.b_axis  = st[5].b_axis;
    job.b_bound = st[5].b_bound;
    job.tmax_n  = st[5].tmax_n[COORD_WIDTH-1:0];
    job.tmax_d  = st[5].tmax_d;
  end

endmodule

// ===== rtl/core/slc_queue.sv =====
// Short job queue between the front end and the back end.
module slc_queue import slc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  slc_job_t wr_job,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output slc_job_t rd_job
);

  slc_job_t        mem [QDEPTH];
  logic [QPTR-1:0] wr_ptr, rd_ptr;
  logic [QPTR:0]   count;

  assign full   = count == (QPTR+1)'(QDEPTH);
  assign empty  = count == '0;
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR+1)'(QDEPTH)) else $error("queue count overflow");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && empty)) else $error("queue overrun");
  a_cnt_inc: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("queue count");
`endif

endmodule

// ===== rtl/core/slc_back.sv =====
// Back end: endpoint interpolation through a pipelined restoring divider.
module slc_back import slc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_empty,
  input  slc_job_t job,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_ready,
  output slc_out_t out_data
);

  function automatic slc_ep_t ep_prep(slc_axis_t axis, coord_t bound, mag_t n, mag_t den,
                                      slc_in_t pt);
    slc_ep_t                      ep;
    coord_t                       endc;
    num_t                         dj, ndj;
    mag_t                         adj;
    logic [2*COORD_WIDTH-1:0]     prod;
    ep.axis  = axis;
    ep.bound = bound;
    ep.base  = (axis == AX_X) ? pt.start_y : pt.start_x;
    endc     = (axis == AX_X) ? pt.end_y : pt.end_x;
    dj       = num_t'(endc) - num_t'(ep.base);
    ndj      = -dj;
    adj      = dj[NUM_WIDTH-1] ? ndj[COORD_WIDTH-1:0] : dj[COORD_WIDTH-1:0];
    ep.neg   = (n != '0) && dj[NUM_WIDTH-1];
    ep.den   = den;
    prod     = (2*COORD_WIDTH)'(n) * (2*COORD_WIDTH)'(adj);
    ep.rem   = prod[2*COORD_WIDTH-1:COORD_WIDTH];
    ep.lo    = prod[COORD_WIDTH-1:0];
    return ep;
  endfunction

  function automatic slc_ep_t ep_step(slc_ep_t ep);
    slc_ep_t            r;
    logic [COORD_WIDTH:0] t, diff;
    logic               ge;
    r    = ep;
    t    = {ep.rem, ep.lo[COORD_WIDTH-1]};
    diff = t - {1'b0, ep.den};
    ge   = t >= {1'b0, ep.den};
    r.rem = ge ? diff[COORD_WIDTH-1:0] : t[COORD_WIDTH-1:0];
    r.lo  = {ep.lo[COORD_WIDTH-2:0], ge};
    return r;
  endfunction

  function automatic coord_t ep_coord(slc_ep_t ep);
    logic                        rnz;
    logic signed [COORD_WIDTH+1:0] q, fl, c;
    rnz = ep.rem != '0;
    q   = $signed({2'b00, ep.lo});
    fl  = ep.neg ? -q - $signed({{(COORD_WIDTH+1){1'b0}}, rnz}) : q;
    c   = $signed({{2{ep.base[COORD_WIDTH-1]}}, ep.base}) + fl;
    if (rnz && c[COORD_WIDTH+1]) c = c + 1'b1;
    return c[COORD_WIDTH-1:0];
  endfunction

  slc_bst_t                 bs [COORD_WIDTH+1];
  logic [COORD_WIDTH:0]     bv;
  logic                     adv;
  slc_out_t                 res;

  assign adv = !out_valid || out_ready;
  assign pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      bv        <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      bv        <= {bv[COORD_WIDTH-1:0], !q_empty};
      out_valid <= bv[COORD_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bs[0].ok <= job.ok;
      bs[0].pt <= job.pt;
      bs[0].a  <= ep_prep(job.a_axis, job.a_bound, job.tmin_n, job.tmin_d, job.pt);
      bs[0].b  <= ep_prep(job.b_axis, job.b_bound, job.tmax_n, job.tmax_d, job.pt);
      for (int k = 1; k <= COORD_WIDTH; k++) begin
        bs[k].ok <= bs[k-1].ok;
        bs[k].pt <= bs[k-1].pt;
        bs[k].a  <= ep_step(bs[k-1].a);
        bs[k].b  <= ep_step(bs[k-1].b);
      end
      out_data <= res;
    end
  end

  always_comb begin
    slc_bst_t f;
    coord_t   ca, cb;
    f  = bs[COORD_WIDTH];
    ca = ep_coord(f.a);
    cb = ep_coord(f.b);
    res.visible     = f.ok;
    res.out_start_x = f.pt.start_x;
    res.out_start_y = f.pt.start_y;
    res.out_end_x   = f.pt.end_x;
    res.out_end_y   = f.pt.end_y;
    if (f.ok) begin
      unique case (f.a.axis)
        AX_X: begin
          res.out_start_x = f.a.bound;
          res.out_start_y = ca;
        end
        AX_Y: begin
          res.out_start_y = f.a.bound;
          res.out_start_x = ca;
        end
        default: ;
      endcase
      unique case (f.b.axis)
        AX_X: begin
          res.out_end_x = f.b.bound;
          res.out_end_y = cb;
        end
        AX_Y: begin
          res.out_end_y = f.b.bound;
          res.out_end_x = cb;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/segment_rectangle_clipper.sv =====
// Top level of the segment rectangle clipper.
// Clips each segment word against the rectangle held in four registers (left, top, right,
// bottom, written through cfg_we/cfg_index/cfg_data; the user must write them only while
// idle, which the block does not enforce). One segment is accepted per cycle while in_ready
// is high. Each segment passes through the front-end classification and cross-product
// registers, the queue, the multiply register heading the back end, the bit-per-stage
// divider that interpolates the moved endpoints, and the output register. A four-word
// queue between front and back end absorbs short output stalls.
module segment_rectangle_clipper import slc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  coord_t     cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  slc_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output slc_out_t   out_data
);

  logic     q_full, q_empty, push, pop;
  slc_job_t wr_job, rd_job;

  slc_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_data,
    .q_full, .push, .job(wr_job)
  );

  slc_queue u_queue (
    .clk, .rst, .push, .wr_job, .full(q_full),
    .pop, .empty(q_empty), .rd_job
  );

  slc_back u_back (
    .clk, .rst, .q_empty, .job(rd_job), .pop,
    .out_valid, .out_ready, .out_data
  );

endmodule
